### rtl/core/text_console_char_engine_unit_defines.svh
// Assertion helpers shared by the console engine RTL.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define TCCE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tcce_pkg.sv
package tcce_pkg;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [7:0] CH_BS      = 8'd8;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_FF      = 8'd12;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] PRINT_LO   = 8'd32;
	localparam logic [7:0] PRINT_HI   = 8'd126;
	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] ATTR_RESET = 8'h0F;
	localparam int         TAB_STEP   = 8;

	typedef struct packed {
		logic       opcode;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [15:0] cell_value;
		logic        scrolled;
	} rsp_t;

	// Memory action implied by a character code.
	typedef struct packed {
		logic printable;
		logic scroll;
		logic clear;
	} act_t;

endpackage

### rtl/core/tcce_cursor.sv
module tcce_cursor
	import tcce_pkg::*;
#(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25,
	localparam int CW = $clog2(SCREEN_COLS),
	localparam int RW = $clog2(SCREEN_ROWS)
) (
	input  logic [7:0]    char_code,
	input  logic [RW-1:0] row,
	input  logic [CW-1:0] col,
	output act_t          act,
	output logic [RW-1:0] row_nxt,
	output logic [CW-1:0] col_nxt
);

	localparam int CW1 = CW + 1;
	localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLS - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);
	localparam logic [CW-1:0] TAB_MASK = ~CW'(TAB_STEP - 1);

	logic [CW:0] tab_sum;
	logic        tab_over;

	// Round down to a tab stop, then step to the next one.
	assign tab_sum  = {1'b0, col & TAB_MASK} + CW1'(TAB_STEP);
	assign tab_over = tab_sum > {1'b0, COL_LAST};

	always_comb begin
		act     = '0;
		row_nxt = row;
		col_nxt = col;
		if (char_code >= PRINT_LO && char_code <= PRINT_HI) begin
			act.printable = 1'b1;
			if (col != COL_LAST) begin
				col_nxt = col + 1'b1;
			end else if (row != ROW_LAST) begin
				row_nxt = row + 1'b1;
				col_nxt = '0;
			end else begin
				act.scroll = 1'b1;
				col_nxt    = '0;
			end
		end else begin
			case (char_code)
				CH_BS: begin
					if (col != '0) begin
						col_nxt = col - 1'b1;
					end
				end
				CH_TAB: begin
					col_nxt = tab_over ? COL_LAST : tab_sum[CW-1:0];
				end
				CH_LF: begin
					col_nxt = '0;
					if (row == ROW_LAST) begin
						act.scroll = 1'b1;
					end else begin
						row_nxt = row + 1'b1;
					end
				end
				CH_FF: begin
					act.clear = 1'b1;
					row_nxt   = '0;
					col_nxt   = '0;
				end
				CH_CR: begin
					col_nxt = '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### rtl/core/text_console_char_engine_unit.sv
// Text console engine: a SCREEN_ROWS x SCREEN_COLS screen of 16-bit cells
// (attribute high byte, character low byte) in one single-port-write memory
// with a registered read. A transaction is taken when start is high and
// busy is low; its result appears on result for exactly one cycle with done
// high and must be captured then. Printable characters, cursor controls and
// out-of-range reads finish from the execute state; an in-range cell read
// also passes through a read state. A scroll (printable at the bottom-right
// corner, or line feed on the last row) moves each cell up one row through
// the memory read port and back, one cell a cycle, and blanks the last row;
// a form feed writes every cell once with a blank. After reset busy stays
// high while the screen is written with blanks; attribute writes are taken
// at any time.
`include "text_console_char_engine_unit_defines.svh"

module text_console_char_engine_unit
	import tcce_pkg::*;
#(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output rsp_t       result,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(CELLS + 1);
	localparam int CW    = $clog2(SCREEN_COLS);
	localparam int RW    = $clog2(SCREEN_ROWS);

	localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_READ   = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;

	logic [15:0] mem [CELLS];

	logic [2:0]    state_q;
	logic [IW-1:0] idx_q;
	logic [15:0]   fill_q;
	logic [7:0]    attr_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic          ff_pend_q;
	logic          done_q;
	cmd_t          cmd_q;
	rsp_t          res_q;
	logic [15:0]   rd_q;

	logic          wr_s1;
	logic          blank_s1;
	logic [AW-1:0] addr_s1;

	act_t          act;
	logic [RW-1:0] row_nxt;
	logic [CW-1:0] col_nxt;

	logic          is_read;
	logic          rd_in_range;
	logic [AW-1:0] rd_cell_addr;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] scr_src;
	logic [15:0]   blank_cell;
	logic [RW-1:0] res_row;
	logic [CW-1:0] res_col;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic [AW-1:0] mem_ra;

	tcce_cursor #(
		.SCREEN_COLS(SCREEN_COLS),
		.SCREEN_ROWS(SCREEN_ROWS)
	) u_cursor (
		.char_code(cmd_q.char_code),
		.row      (cur_row_q),
		.col      (cur_col_q),
		.act      (act),
		.row_nxt  (row_nxt),
		.col_nxt  (col_nxt)
	);

	assign is_read      = cmd_q.opcode == OP_READ;
	assign rd_in_range  = (32'(cmd_q.read_row) < 32'(SCREEN_ROWS)) &&
	                      (32'(cmd_q.read_col) < 32'(SCREEN_COLS));
	assign rd_cell_addr = AW'(32'(cmd_q.read_row) * 32'(SCREEN_COLS) + 32'(cmd_q.read_col));
	assign cur_addr     = AW'(32'(cur_row_q) * 32'(SCREEN_COLS) + 32'(cur_col_q));
	assign scr_src      = AW'(32'(idx_q) + 32'(SCREEN_COLS));
	assign blank_cell   = {attr_q, BLANK_CHAR};

	// One write a cycle: scroll pipeline, clearing sweep, or a printable store.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_addr;
		mem_wd = {attr_q, cmd_q.char_code};
		mem_ra = rd_cell_addr;
		if (wr_s1) begin
			mem_we = 1'b1;
			mem_wa = addr_s1;
			mem_wd = blank_s1 ? blank_cell : rd_q;
		end else if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = idx_q[AW-1:0];
			mem_wd = fill_q;
		end else if (state_q == ST_EXEC && !is_read && act.printable) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_SCROLL) begin
			mem_ra = scr_src;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_comb begin
		res_row = cur_row_q;
		res_col = cur_col_q;
		if (state_q == ST_EXEC && !is_read) begin
			res_row = row_nxt;
			res_col = col_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			idx_q     <= '0;
			fill_q    <= {ATTR_RESET, BLANK_CHAR};
			attr_q    <= ATTR_RESET;
			cur_row_q <= '0;
			cur_col_q <= '0;
			ff_pend_q <= 1'b0;
			wr_s1     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			wr_s1  <= 1'b0;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(CELLS - 1)) begin
						state_q   <= ST_IDLE;
						done_q    <= ff_pend_q;
						ff_pend_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_read) begin
						if (rd_in_range) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end else begin
						cur_row_q <= row_nxt;
						cur_col_q <= col_nxt;
						idx_q     <= '0;
						if (act.clear) begin
							state_q   <= ST_CLEAR;
							fill_q    <= blank_cell;
							ff_pend_q <= 1'b1;
						end else if (act.scroll) begin
							state_q <= ST_SCROLL;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_SCROLL: begin
					// Issue one cell per cycle; the last write drains at the end.
					if (idx_q == IW'(CELLS)) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						wr_s1 <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		addr_s1  <= idx_q[AW-1:0];
		blank_s1 <= idx_q >= IW'(CELLS - SCREEN_COLS);
		res_q.cursor_row <= 5'(res_row);
		res_q.cursor_col <= 7'(res_col);
		res_q.cell_value <= (state_q == ST_READ) ? rd_q : 16'h0000;
		res_q.scrolled   <= state_q == ST_SCROLL;
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = res_q;

	`TCCE_ASSERT_SAME(a_done_idle, clk, arst_n, done_q, state_q == ST_IDLE,
		"result strobe while engine still busy")
	`TCCE_ASSERT_NEXT(a_accept_exec, clk, arst_n, start && !busy, state_q == ST_EXEC,
		"accepted transaction did not enter execute")
	`TCCE_ASSERT_SAME(a_scroll_cursor, clk, arst_n, state_q == ST_SCROLL,
		cur_row_q == ROW_LAST && cur_col_q == '0, "cursor not on last row during scroll")
	`TCCE_ASSERT_SAME(a_s1_scroll, clk, arst_n, wr_s1, state_q == ST_SCROLL,
		"scroll write pending outside scroll")

endmodule
